### src/tsvl_pkg.sv
// Shared constants, types and register indexes for the velocity slew limiter.
package tsvl_pkg;

    localparam int VEL_WIDTH = 16;
    localparam int IO_W      = 16;
    localparam int REG_W     = 15;
    localparam int NUM_REGS  = 8;
    localparam int IDX_W     = $clog2(NUM_REGS);

    // Working width: room for held +/- step and target - held without overflow.
    localparam int CALC_W = ((VEL_WIDTH > IO_W) ? VEL_WIDTH : IO_W) + 2;

    localparam logic [REG_W-1:0] DEAD_ZONE_YAW = REG_W'(0);

    localparam logic signed [CALC_W-1:0] VEL_HI =
        CALC_W'((64'sd1 <<< (VEL_WIDTH - 1)) - 64'sd1);
    localparam logic signed [CALC_W-1:0] VEL_LO = -VEL_HI - CALC_W'(1);

    localparam logic [REG_W-1:0] STEP_RESET = REG_W'(32767);
    localparam logic [REG_W-1:0] VMAX_RESET = REG_W'(32767);
    localparam logic [REG_W-1:0] DEAD_RESET = REG_W'(0);

    localparam logic [IDX_W-1:0] REG_STEP_X   = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_STEP_Y   = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_STEP_YAW = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_VMAX_X   = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_VMAX_Y   = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_VMAX_YAW = IDX_W'(5);
    localparam logic [IDX_W-1:0] REG_DEAD_X   = IDX_W'(6);
    localparam logic [IDX_W-1:0] REG_DEAD_Y   = IDX_W'(7);

    typedef logic signed [VEL_WIDTH-1:0] held_t;
    typedef logic signed [IO_W-1:0]      io_vel_t;
    typedef logic [REG_W-1:0]            reg_val_t;

    typedef struct packed {
        reg_val_t step_x;
        reg_val_t step_y;
        reg_val_t step_yaw;
        reg_val_t vmax_x;
        reg_val_t vmax_y;
        reg_val_t vmax_yaw;
        reg_val_t dead_x;
        reg_val_t dead_y;
    } cfg_t;

endpackage

### src/tsvl_ifs.sv
// Valid/ready channel interfaces for desired and limited velocities.
interface tsvl_want_if
    import tsvl_pkg::*;
;
    logic    valid;
    logic    ready;
    io_vel_t want_x;
    io_vel_t want_y;
    io_vel_t want_yaw;

    modport source (output valid, output want_x, output want_y, output want_yaw,
                    input ready);
    modport sink   (input valid, input want_x, input want_y, input want_yaw,
                    output ready);
endinterface

interface tsvl_vel_if
    import tsvl_pkg::*;
;
    logic    valid;
    logic    ready;
    io_vel_t vel_x;
    io_vel_t vel_y;
    io_vel_t vel_yaw;

    modport source (output valid, output vel_x, output vel_y, output vel_yaw,
                    input ready);
    modport sink   (input valid, input vel_x, input vel_y, input vel_yaw,
                    output ready);
endinterface

### src/three_axis_velocity_slew_limiter.sv
// Top level of the three-axis velocity slew limiter.
//
// Usage:
//   want channel (sink): one item of desired x, y and yaw velocities, Q4.12.
//   vel channel (source): one item of limited velocities per input item.
//   wr_en/wr_index/wr_data: register writes, taken on any edge with wr_en high;
//   write only while no item is in flight.
// Flow: an accepted item is held in the input register; once the result register
//   is free, the three axis units (deadband, slew step, clamp) load the result
//   register and the held velocities from it.
// Throughput: one item per cycle while vel.ready stays high, set by the single
//   combinational pass per axis between input and result registers.
// Reset: held velocities go to zero, steps and limits to full scale, deadbands
//   to zero; both pipeline registers are empty.
// Stall: while vel.ready is low the result holds; the input register keeps one
//   more item, then want.ready drops until the result is taken.
module three_axis_velocity_slew_limiter
    import tsvl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    tsvl_want_if.sink        want,
    tsvl_vel_if.source       vel,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_index,
    input  reg_val_t         wr_data
);

    cfg_t    cfg;

    logic    in_vld_reg;
    io_vel_t in_x_reg;
    io_vel_t in_y_reg;
    io_vel_t in_yaw_reg;

    logic    out_vld_reg;
    io_vel_t out_x_reg;
    io_vel_t out_y_reg;
    io_vel_t out_yaw_reg;

    held_t   held_x_reg;
    held_t   held_y_reg;
    held_t   held_yaw_reg;
    held_t   held_x_next;
    held_t   held_y_next;
    held_t   held_yaw_next;
    io_vel_t vel_x_next;
    io_vel_t vel_y_next;
    io_vel_t vel_yaw_next;

    logic    out_free;
    logic    advance;
    logic    take_in;

    tsvl_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    tsvl_axis u_axis_x (
        .held      (held_x_reg),
        .want      (in_x_reg),
        .dead      (cfg.dead_x),
        .step      (cfg.step_x),
        .vmax      (cfg.vmax_x),
        .held_next (held_x_next),
        .vel       (vel_x_next)
    );

    tsvl_axis u_axis_y (
        .held      (held_y_reg),
        .want      (in_y_reg),
        .dead      (cfg.dead_y),
        .step      (cfg.step_y),
        .vmax      (cfg.vmax_y),
        .held_next (held_y_next),
        .vel       (vel_y_next)
    );

    tsvl_axis u_axis_yaw (
        .held      (held_yaw_reg),
        .want      (in_yaw_reg),
        .dead      (DEAD_ZONE_YAW),
        .step      (cfg.step_yaw),
        .vmax      (cfg.vmax_yaw),
        .held_next (held_yaw_next),
        .vel       (vel_yaw_next)
    );

    assign out_free   = !out_vld_reg || vel.ready;
    assign advance    = in_vld_reg && out_free;
    assign want.ready = !in_vld_reg || out_free;
    assign take_in    = want.valid && want.ready;

    // control and held state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
            held_x_reg   <= '0;
            held_y_reg   <= '0;
            held_yaw_reg <= '0;
        end
        else
        begin
            if (take_in)
                in_vld_reg <= 1'b1;
            else if (advance)
                in_vld_reg <= 1'b0;

            if (advance)
                out_vld_reg <= 1'b1;
            else if (vel.ready)
                out_vld_reg <= 1'b0;

            if (advance)
            begin
                held_x_reg   <= held_x_next;
                held_y_reg   <= held_y_next;
                held_yaw_reg <= held_yaw_next;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_x_reg   <= want.want_x;
            in_y_reg   <= want.want_y;
            in_yaw_reg <= want.want_yaw;
        end
        if (advance)
        begin
            out_x_reg   <= vel_x_next;
            out_y_reg   <= vel_y_next;
            out_yaw_reg <= vel_yaw_next;
        end
    end

    assign vel.valid   = out_vld_reg;
    assign vel.vel_x   = out_x_reg;
    assign vel.vel_y   = out_y_reg;
    assign vel.vel_yaw = out_yaw_reg;

endmodule

### src/tsvl_cfg.sv
// Configuration register file: steps, limits and deadbands.
module tsvl_cfg
    import tsvl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_index,
    input  reg_val_t         wr_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_STEP_X:   cfg_next.step_x   = wr_data;
                REG_STEP_Y:   cfg_next.step_y   = wr_data;
                REG_STEP_YAW: cfg_next.step_yaw = wr_data;
                REG_VMAX_X:   cfg_next.vmax_x   = wr_data;
                REG_VMAX_Y:   cfg_next.vmax_y   = wr_data;
                REG_VMAX_YAW: cfg_next.vmax_yaw = wr_data;
                REG_DEAD_X:   cfg_next.dead_x   = wr_data;
                REG_DEAD_Y:   cfg_next.dead_y   = wr_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_x   <= STEP_RESET;
            cfg_reg.step_y   <= STEP_RESET;
            cfg_reg.step_yaw <= STEP_RESET;
            cfg_reg.vmax_x   <= VMAX_RESET;
            cfg_reg.vmax_y   <= VMAX_RESET;
            cfg_reg.vmax_yaw <= VMAX_RESET;
            cfg_reg.dead_x   <= DEAD_RESET;
            cfg_reg.dead_y   <= DEAD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/tsvl_axis.sv
// One axis: deadband, slew step toward target, limit clamp, width saturation.
module tsvl_axis
    import tsvl_pkg::*;
(
    input  held_t    held,
    input  io_vel_t  want,
    input  reg_val_t dead,
    input  reg_val_t step,
    input  reg_val_t vmax,
    output held_t    held_next,
    output io_vel_t  vel
);

    logic signed [CALC_W-1:0] want_w;
    logic signed [CALC_W-1:0] want_mag;
    logic signed [CALC_W-1:0] dead_w;
    logic signed [CALC_W-1:0] step_w;
    logic signed [CALC_W-1:0] vmax_w;
    logic signed [CALC_W-1:0] held_w;
    logic signed [CALC_W-1:0] target;
    logic signed [CALC_W-1:0] diff;
    logic signed [CALC_W-1:0] diff_mag;
    logic signed [CALC_W-1:0] slewed;
    logic signed [CALC_W-1:0] limited;
    logic signed [CALC_W-1:0] sat;

    always_comb
    begin
        want_w   = CALC_W'(want);
        held_w   = CALC_W'(held);
        dead_w   = signed'(CALC_W'(dead));
        step_w   = signed'(CALC_W'(step));
        vmax_w   = signed'(CALC_W'(vmax));

        // most negative input gives magnitude 32768, representable here
        want_mag = want_w[CALC_W-1] ? -want_w : want_w;
        target   = (want_mag < dead_w) ? '0 : want_w;

        diff     = target - held_w;
        diff_mag = diff[CALC_W-1] ? -diff : diff;
        if (diff_mag > step_w)
            slewed = diff[CALC_W-1] ? (held_w - step_w) : (held_w + step_w);
        else
            slewed = target;

        priority if (slewed < -vmax_w)
            limited = -vmax_w;
        else if (slewed > vmax_w)
            limited = vmax_w;
        else
            limited = slewed;

        priority if (limited < VEL_LO)
            sat = VEL_LO;
        else if (limited > VEL_HI)
            sat = VEL_HI;
        else
            sat = limited;
    end

    assign held_next = sat[VEL_WIDTH-1:0];
    assign vel       = sat[IO_W-1:0];

endmodule
